// ===== hdl/i2cm_pkg.sv =====
// ============================================================================
// I2C master bit engine package
// Shared types, command codes, register indexes and reset values of the I2C
// master bit engine.
// ============================================================================
package i2cm_pkg;

    localparam int TIMER_BITS_DEF = 8;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_START_STOP_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BIT_HALF        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ACK_TIMEOUT     = 2'd2;

    localparam logic [7:0] START_STOP_HOLD_RST = 8'd4;
    localparam logic [7:0] BIT_HALF_RST        = 8'd2;
    localparam logic [7:0] ACK_TIMEOUT_RST     = 8'd250;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_READ     = 3'd4,
        CMD_WAIT_ACK = 3'd5,
        CMD_ACK      = 3'd6,
        CMD_NACK     = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [7:0] start_stop_hold;
        logic [7:0] bit_half;
        logic [7:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_fail;
    } res_t;

endpackage

// ===== hdl/i2cm_core.sv =====
// ============================================================================
// I2C master bit engine sequencer
// Command state, segment timer, shift register and line registers. One tick
// is processed per step; the result of the tick is presented combinationally.
// ============================================================================
module i2cm_core #(
    parameter int TIMER_BITS = i2cm_pkg::TIMER_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [2:0]       cmd_in,
    input  logic [7:0]       tx_byte,
    input  logic             ack_after_read,
    input  logic             sda_in,
    input  i2cm_pkg::cfg_t   cfg,
    output i2cm_pkg::res_t   res
);

    localparam logic [16:0] TICK_MAX = 17'((17'd1 << TIMER_BITS) - 17'd1);

    function automatic logic [TIMER_BITS-1:0] hold_load(input logic [7:0] v);
        logic [16:0] d;
        begin
            d = (v == 8'd0) ? 17'd0 : ({9'd0, v} - 17'd1);
            if (d > TICK_MAX) begin
                d = TICK_MAX;
            end
            return d[TIMER_BITS-1:0];
        end
    endfunction

    i2cm_pkg::cmd_t        cmd_new;
    i2cm_pkg::cmd_t        act_reg, act_next;
    logic [2:0]            phase_reg, phase_next;
    logic [TIMER_BITS-1:0] tick_reg, tick_next;
    logic [3:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic [7:0]            poll_reg, poll_next;
    logic [7:0]            rx_reg, rx_next;
    logic                  fail_reg, fail_next;
    logic                  ack_sel_reg, ack_sel_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  drv_reg, drv_next;

    logic [TIMER_BITS-1:0] ld_hold, ld_bit;
    logic                  e_go;
    logic [2:0]            e_ph;
    logic                  do_poll;
    logic                  poll_done;
    logic                  is_last;
    logic                  done;

    assign cmd_new = i2cm_pkg::cmd_t'(cmd_in);
    assign ld_hold = hold_load(cfg.start_stop_hold);
    assign ld_bit  = hold_load(cfg.bit_half);

    always_comb begin
        act_next     = act_reg;
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        poll_next    = poll_reg;
        rx_next      = rx_reg;
        fail_next    = fail_reg;
        ack_sel_next = ack_sel_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        drv_next     = drv_reg;
        e_go         = 1'b0;
        e_ph         = 3'd0;
        do_poll      = 1'b0;
        poll_done    = 1'b0;
        is_last      = 1'b0;
        done         = 1'b0;

        if (act_reg == i2cm_pkg::CMD_NONE) begin
            if (cmd_new != i2cm_pkg::CMD_NONE) begin
                act_next   = cmd_new;
                bit_next   = 4'd0;
                poll_next  = 8'd0;
                shift_next = (cmd_new == i2cm_pkg::CMD_WRITE) ? tx_byte : 8'd0;
                if (cmd_new == i2cm_pkg::CMD_READ) begin
                    ack_sel_next = ack_after_read;
                end else if (cmd_new == i2cm_pkg::CMD_ACK) begin
                    ack_sel_next = 1'b1;
                end else if (cmd_new == i2cm_pkg::CMD_NACK) begin
                    ack_sel_next = 1'b0;
                end
                e_go = 1'b1;
                e_ph = (cmd_new == i2cm_pkg::CMD_ACK || cmd_new == i2cm_pkg::CMD_NACK)
                       ? 3'd2 : 3'd0;
            end
        end else if (act_reg == i2cm_pkg::CMD_WAIT_ACK && phase_reg == 3'd2) begin
            do_poll = 1'b1;
        end else if (tick_reg != '0) begin
            tick_next = tick_reg - 1'b1;
        end else begin
            case (act_reg)
                i2cm_pkg::CMD_WRITE: begin
                    e_go = 1'b1;
                    if (phase_reg < 3'd2) begin
                        e_ph = phase_reg + 3'd1;
                    end else begin
                        bit_next   = bit_reg + 4'd1;
                        shift_next = {shift_reg[6:0], 1'b0};
                        e_ph       = 3'd0;
                    end
                end
                i2cm_pkg::CMD_READ, i2cm_pkg::CMD_ACK, i2cm_pkg::CMD_NACK: begin
                    e_go = 1'b1;
                    if (phase_reg == 3'd1) begin
                        bit_next = bit_reg + 4'd1;
                        if (bit_reg >= 4'd7) begin
                            rx_next = shift_reg;
                            e_ph    = 3'd2;
                        end else begin
                            e_ph = 3'd0;
                        end
                    end else begin
                        e_ph = phase_reg + 3'd1;
                    end
                end
                i2cm_pkg::CMD_WAIT_ACK: begin
                    if (phase_reg == 3'd0) begin
                        e_go = 1'b1;
                        e_ph = 3'd1;
                    end else begin
                        do_poll = 1'b1;
                    end
                end
                default: begin
                    e_go = 1'b1;
                    e_ph = phase_reg + 3'd1;
                end
            endcase
        end

        if (do_poll) begin
            phase_next = 3'd2;
            if (!sda_in) begin
                scl_next  = 1'b0;
                fail_next = 1'b0;
                poll_done = 1'b1;
            end else if (poll_reg >= cfg.ack_timeout) begin
                fail_next = 1'b1;
                act_next  = i2cm_pkg::CMD_STOP;
                e_go      = 1'b1;
                e_ph      = 3'd0;
            end else begin
                poll_next = poll_reg + 8'd1;
            end
        end

        if (e_go) begin
            phase_next = e_ph;
            tick_next  = '0;
            case (act_next)
                i2cm_pkg::CMD_START: begin
                    if (e_ph == 3'd0) begin
                        scl_next  = 1'b1;
                        sda_next  = 1'b1;
                        drv_next  = 1'b1;
                        tick_next = ld_hold;
                    end else if (e_ph == 3'd1) begin
                        sda_next  = 1'b0;
                        tick_next = ld_hold;
                    end else begin
                        scl_next = 1'b0;
                    end
                end
                i2cm_pkg::CMD_STOP: begin
                    scl_next  = (e_ph != 3'd0);
                    sda_next  = (e_ph != 3'd0);
                    drv_next  = 1'b1;
                    tick_next = ld_hold;
                end
                i2cm_pkg::CMD_WRITE: begin
                    if (e_ph == 3'd0) begin
                        scl_next = 1'b0;
                        sda_next = shift_next[7];
                        drv_next = 1'b1;
                    end else begin
                        scl_next = (e_ph == 3'd1);
                    end
                    tick_next = ld_bit;
                end
                i2cm_pkg::CMD_READ, i2cm_pkg::CMD_ACK, i2cm_pkg::CMD_NACK: begin
                    if (e_ph == 3'd0) begin
                        scl_next  = 1'b0;
                        sda_next  = 1'b1;
                        drv_next  = 1'b0;
                        tick_next = ld_bit;
                    end else if (e_ph == 3'd1) begin
                        scl_next   = 1'b1;
                        shift_next = {shift_next[6:0], sda_in};
                    end else if (e_ph == 3'd2) begin
                        scl_next  = 1'b0;
                        sda_next  = !ack_sel_next;
                        drv_next  = 1'b1;
                        tick_next = ld_bit;
                    end else if (e_ph == 3'd3) begin
                        scl_next  = 1'b1;
                        tick_next = ld_bit;
                    end else begin
                        scl_next = 1'b0;
                    end
                end
                i2cm_pkg::CMD_WAIT_ACK: begin
                    if (e_ph == 3'd0) begin
                        sda_next = 1'b1;
                        drv_next = 1'b0;
                    end else begin
                        scl_next = 1'b1;
                    end
                end
                default: begin
                    tick_next = '0;
                end
            endcase
        end

        case (act_next)
            i2cm_pkg::CMD_START: is_last = (phase_next == 3'd2);
            i2cm_pkg::CMD_STOP:  is_last = (phase_next == 3'd1);
            i2cm_pkg::CMD_WRITE: is_last = (phase_next == 3'd2) && (bit_next == 4'd7);
            i2cm_pkg::CMD_READ, i2cm_pkg::CMD_ACK, i2cm_pkg::CMD_NACK: begin
                is_last = (phase_next == 3'd4);
            end
            default:             is_last = 1'b0;
        endcase

        done = poll_done || (is_last && tick_next == '0);
        if (done) begin
            act_next   = i2cm_pkg::CMD_NONE;
            phase_next = 3'd0;
            tick_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg     <= i2cm_pkg::CMD_NONE;
            phase_reg   <= 3'd0;
            tick_reg    <= '0;
            bit_reg     <= 4'd0;
            shift_reg   <= 8'd0;
            poll_reg    <= 8'd0;
            rx_reg      <= 8'd0;
            fail_reg    <= 1'b0;
            ack_sel_reg <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            drv_reg     <= 1'b1;
        end else if (step) begin
            act_reg     <= act_next;
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            poll_reg    <= poll_next;
            rx_reg      <= rx_next;
            fail_reg    <= fail_next;
            ack_sel_reg <= ack_sel_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            drv_reg     <= drv_next;
        end
    end

    assign res.scl       = scl_next;
    assign res.sda_out   = sda_next;
    assign res.sda_drive = drv_next;
    assign res.busy      = (act_next != i2cm_pkg::CMD_NONE);
    assign res.done      = done;
    assign res.rx_byte   = rx_next;
    assign res.ack_fail  = fail_next;

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.done |=> act_reg == i2cm_pkg::CMD_NONE)
        else $error("Command still active after its final tick.");

    a_new_cmd_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        step && act_reg == i2cm_pkg::CMD_NONE && cmd_new != i2cm_pkg::CMD_NONE
        |=> act_reg != i2cm_pkg::CMD_NONE)
        else $error("A new command finished on its first tick.");

    a_no_step_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(act_reg) && $stable(tick_reg) && $stable(scl_reg))
        else $error("Sequencer state moved without an accepted word.");

    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_reg <= 4'd8)
        else $error("Bit index ran past the end of the byte.");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= 3'd4)
        else $error("Phase outside the segment sequence.");

endmodule

// ===== hdl/i2c_master_bit_engine.sv =====
// A result word is presented in the cycle after its tick word is accepted.
// Throughput: a tick word per cycle unless stalled; one sequencer step per word.
// The single output register is refilled in the cycle it is drained.
// Reset (aresetn low, synchronous): engine idle, SCL and SDA high and driven,
// received byte and failure flag cleared, registers at 4, 2 and 250.
// ============================================================================
// I2C master bit engine
// Tick-driven I2C master: start, stop, byte write, byte read, acknowledge
// and acknowledge wait with timeout, with a configuration write port.
// ============================================================================
module i2c_master_bit_engine #(
    parameter int TIMER_BITS = i2cm_pkg::TIMER_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_command,
    input  logic [7:0]                    s_tx_byte,
    input  logic                          s_ack_after_read,
    input  logic                          s_sda_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_scl,
    output logic                          m_sda_out,
    output logic                          m_sda_drive,
    output logic                          m_busy_res,
    output logic                          m_done_res,
    output logic [7:0]                    m_rx_byte,
    output logic                          m_ack_fail
);

    i2cm_pkg::cfg_t cfg_reg;
    i2cm_pkg::res_t res_now;
    i2cm_pkg::res_t out_reg;
    logic           m_valid_reg;
    logic           step;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign step      = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_stop_hold <= i2cm_pkg::START_STOP_HOLD_RST;
            cfg_reg.bit_half        <= i2cm_pkg::BIT_HALF_RST;
            cfg_reg.ack_timeout     <= i2cm_pkg::ACK_TIMEOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                i2cm_pkg::CFG_IDX_START_STOP_HOLD: cfg_reg.start_stop_hold <= cfg_data;
                i2cm_pkg::CFG_IDX_BIT_HALF:        cfg_reg.bit_half        <= cfg_data;
                i2cm_pkg::CFG_IDX_ACK_TIMEOUT:     cfg_reg.ack_timeout     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    i2cm_core #(
        .TIMER_BITS(TIMER_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .cmd_in        (s_command),
        .tx_byte       (s_tx_byte),
        .ack_after_read(s_ack_after_read),
        .sda_in        (s_sda_in),
        .cfg           (cfg_reg),
        .res           (res_now)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (step) begin
            out_reg <= res_now;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_scl       = out_reg.scl;
    assign m_sda_out   = out_reg.sda_out;
    assign m_sda_drive = out_reg.sda_drive;
    assign m_busy_res  = out_reg.busy;
    assign m_done_res  = out_reg.done;
    assign m_rx_byte   = out_reg.rx_byte;
    assign m_ack_fail  = out_reg.ack_fail;

endmodule

// ===== dv/i2cm_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// I2C master bit engine line checker
// Watches the tick, result and register channels of the I2C master bit engine,
// predicts the line word that each accepted tick word produces and compares
// every accepted result word with the oldest prediction, field by field.
// ============================================================================
module i2cm_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [2:0]                     s_command,
    input  logic [7:0]                     s_tx_byte,
    input  logic                           s_ack_after_read,
    input  logic                           s_sda_in,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_scl,
    input  logic                           m_sda_out,
    input  logic                           m_sda_drive,
    input  logic                           m_busy_res,
    input  logic                           m_done_res,
    input  logic [7:0]                     m_rx_byte,
    input  logic                           m_ack_fail,
    output int                             fail_count,
    output int                             pending,
    output logic                           engine_busy
);

    logic [7:0] hold_cfg, half_cfg, tmo_cfg;

    i2cm_pkg::cmd_t act;
    logic [3:0]     ph;
    logic [7:0]     tick;
    logic [3:0]     bidx;
    logic [7:0]     shreg;
    logic [7:0]     polls;
    logic           fail_q;
    logic [7:0]     rx_q;
    logic           ack_sel;
    logic           scl_q, sda_q, drv_q;

    i2cm_pkg::res_t lines_due[$];

    assign engine_busy = (act != i2cm_pkg::CMD_NONE);

    // A zero length counts as one tick, so the remaining count is length - 1.
    function automatic logic [7:0] hold_ticks(logic [7:0] len);
        return (len == 8'd0) ? 8'd0 : len - 8'd1;
    endfunction

    function automatic void enter_phase(logic [3:0] p, logic sd);
        logic [7:0] t;
        t = 8'd0;
        ph = p;
        case (act)
            i2cm_pkg::CMD_START: begin
                if (p == 4'd0) begin
                    {scl_q, sda_q, drv_q} = 3'b111;
                    t = hold_ticks(hold_cfg);
                end else if (p == 4'd1) begin
                    sda_q = 1'b0;
                    t = hold_ticks(hold_cfg);
                end else begin
                    scl_q = 1'b0;
                end
            end
            i2cm_pkg::CMD_STOP: begin
                {scl_q, sda_q, drv_q} = (p == 4'd0) ? 3'b001 : 3'b111;
                t = hold_ticks(hold_cfg);
            end
            i2cm_pkg::CMD_WRITE: begin
                if (p == 4'd0) {scl_q, sda_q, drv_q} = {1'b0, shreg[7], 1'b1};
                else scl_q = (p == 4'd1);
                t = hold_ticks(half_cfg);
            end
            i2cm_pkg::CMD_READ, i2cm_pkg::CMD_ACK, i2cm_pkg::CMD_NACK: begin
                case (p)
                    4'd0: begin
                        {scl_q, sda_q, drv_q} = 3'b010;
                        t = hold_ticks(half_cfg);
                    end
                    4'd1: begin
                        scl_q = 1'b1;
                        shreg = {shreg[6:0], sd};
                    end
                    4'd2: begin
                        {scl_q, sda_q, drv_q} = {1'b0, ~ack_sel, 1'b1};
                        t = hold_ticks(half_cfg);
                    end
                    4'd3: begin
                        scl_q = 1'b1;
                        t = hold_ticks(half_cfg);
                    end
                    default: scl_q = 1'b0;
                endcase
            end
            i2cm_pkg::CMD_WAIT_ACK: begin
                if (p == 4'd0) begin
                    sda_q = 1'b1;
                    drv_q = 1'b0;
                end else begin
                    scl_q = 1'b1;
                end
            end
            default: ;
        endcase
        tick = t;
    endfunction

    function automatic logic at_last_phase();
        case (act)
            i2cm_pkg::CMD_START: return ph == 4'd2;
            i2cm_pkg::CMD_STOP:  return ph == 4'd1;
            i2cm_pkg::CMD_WRITE: return ph == 4'd2 && bidx == 4'd7;
            i2cm_pkg::CMD_READ, i2cm_pkg::CMD_ACK, i2cm_pkg::CMD_NACK: return ph == 4'd4;
            default:             return 1'b0;
        endcase
    endfunction

    // One SDA poll of an acknowledge wait; a timeout turns into a stop sequence.
    function automatic logic ack_poll(logic sd);
        if (!sd) begin
            scl_q = 1'b0;
            fail_q = 1'b0;
            return 1'b1;
        end
        if (polls >= tmo_cfg) begin
            fail_q = 1'b1;
            act = i2cm_pkg::CMD_STOP;
            enter_phase(4'd0, sd);
            return 1'b0;
        end
        polls = polls + 8'd1;
        return 1'b0;
    endfunction

    function automatic logic next_phase(logic sd);
        case (act)
            i2cm_pkg::CMD_WRITE: begin
                if (ph < 4'd2) begin
                    enter_phase(ph + 4'd1, sd);
                end else begin
                    bidx = bidx + 4'd1;
                    shreg = {shreg[6:0], 1'b0};
                    enter_phase(4'd0, sd);
                end
                return 1'b0;
            end
            i2cm_pkg::CMD_READ, i2cm_pkg::CMD_ACK, i2cm_pkg::CMD_NACK: begin
                if (ph == 4'd1) begin
                    bidx = bidx + 4'd1;
                    if (bidx >= 4'd8) begin
                        rx_q = shreg;
                        enter_phase(4'd2, sd);
                    end else begin
                        enter_phase(4'd0, sd);
                    end
                end else begin
                    enter_phase(ph + 4'd1, sd);
                end
                return 1'b0;
            end
            i2cm_pkg::CMD_WAIT_ACK: begin
                if (ph == 4'd0) begin
                    enter_phase(4'd1, sd);
                    return 1'b0;
                end
                ph = 4'd2;
                return ack_poll(sd);
            end
            default: begin
                enter_phase(ph + 4'd1, sd);
                return 1'b0;
            end
        endcase
    endfunction

    function automatic i2cm_pkg::res_t line_tick(i2cm_pkg::cmd_t cmd, logic [7:0] tx,
                                                 logic ak, logic sd);
        logic fin;
        i2cm_pkg::res_t r;
        fin = 1'b0;
        if (act == i2cm_pkg::CMD_NONE) begin
            if (cmd != i2cm_pkg::CMD_NONE) begin
                act = cmd;
                bidx = 4'd0;
                polls = 8'd0;
                shreg = (cmd == i2cm_pkg::CMD_WRITE) ? tx : 8'd0;
                if (cmd == i2cm_pkg::CMD_READ) ack_sel = ak;
                else if (cmd == i2cm_pkg::CMD_ACK) ack_sel = 1'b1;
                else if (cmd == i2cm_pkg::CMD_NACK) ack_sel = 1'b0;
                enter_phase((cmd == i2cm_pkg::CMD_ACK || cmd == i2cm_pkg::CMD_NACK)
                            ? 4'd2 : 4'd0, sd);
                fin = at_last_phase() && tick == 8'd0;
            end
        end else if (act == i2cm_pkg::CMD_WAIT_ACK && ph == 4'd2) begin
            fin = ack_poll(sd);
            if (!fin) fin = at_last_phase() && tick == 8'd0;
        end else if (tick > 8'd0) begin
            tick = tick - 8'd1;
            fin = at_last_phase() && tick == 8'd0;
        end else begin
            fin = next_phase(sd);
            if (!fin) fin = at_last_phase() && tick == 8'd0;
        end
        if (fin) begin
            act = i2cm_pkg::CMD_NONE;
            ph = 4'd0;
            tick = 8'd0;
        end
        r.scl       = scl_q;
        r.sda_out   = sda_q;
        r.sda_drive = drv_q;
        r.busy      = (act != i2cm_pkg::CMD_NONE);
        r.done      = fin;
        r.rx_byte   = rx_q;
        r.ack_fail  = fail_q;
        return r;
    endfunction

    task automatic compare_line(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        i2cm_pkg::res_t want;
        if (!aresetn) begin
            hold_cfg = i2cm_pkg::START_STOP_HOLD_RST;
            half_cfg = i2cm_pkg::BIT_HALF_RST;
            tmo_cfg  = i2cm_pkg::ACK_TIMEOUT_RST;
            act      = i2cm_pkg::CMD_NONE;
            ph       = 4'd0;
            tick     = 8'd0;
            bidx     = 4'd0;
            shreg    = 8'd0;
            polls    = 8'd0;
            fail_q   = 1'b0;
            rx_q     = 8'd0;
            ack_sel  = 1'b0;
            {scl_q, sda_q, drv_q} = 3'b111;
            lines_due.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (lines_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result word, expected none, got %0h",
                             $time, {m_scl, m_sda_out, m_sda_drive, m_busy_res,
                                     m_done_res, m_rx_byte, m_ack_fail});
                end else begin
                    want = lines_due.pop_front();
                    compare_line("scl", 8'(want.scl), 8'(m_scl));
                    compare_line("sda_out", 8'(want.sda_out), 8'(m_sda_out));
                    compare_line("sda_drive", 8'(want.sda_drive), 8'(m_sda_drive));
                    compare_line("busy", 8'(want.busy), 8'(m_busy_res));
                    compare_line("done", 8'(want.done), 8'(m_done_res));
                    compare_line("rx_byte", want.rx_byte, m_rx_byte);
                    compare_line("ack_fail", 8'(want.ack_fail), 8'(m_ack_fail));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    i2cm_pkg::CFG_IDX_START_STOP_HOLD: hold_cfg = cfg_data;
                    i2cm_pkg::CFG_IDX_BIT_HALF:        half_cfg = cfg_data;
                    i2cm_pkg::CFG_IDX_ACK_TIMEOUT:     tmo_cfg  = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                lines_due.push_back(line_tick(i2cm_pkg::cmd_t'(s_command), s_tx_byte,
                                              s_ack_after_read, s_sda_in));
            end
        end
        pending = lines_due.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// I2C master bit engine testbench
// Drives tick words carrying I2C commands and SDA levels into the engine under
// several timing settings, with random stalls on both channels, and reports
// the verdict of the line checker.
// ============================================================================
module testbench;

    localparam int QUIET_FROM = 300;
    localparam int QUIET_TO   = 500;

    // Timing settings per phase as {start_stop_hold, bit_half, ack_timeout}.
    localparam logic [0:3][23:0] CFG_PLAN = {
        24'h01_01_01, 24'h00_00_00, 24'h02_03_04, 24'h03_01_FF
    };

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                     cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic [2:0]                     s_command;
    logic [7:0]                     s_tx_byte;
    logic                           s_ack_after_read;
    logic                           s_sda_in;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_scl;
    logic                           m_sda_out;
    logic                           m_sda_drive;
    logic                           m_busy_res;
    logic                           m_done_res;
    logic [7:0]                     m_rx_byte;
    logic                           m_ack_fail;
    int                             fail_count;
    int                             pending;
    logic                           engine_busy;

    int cycle_no = 0;
    int items_sent = 0;

    i2c_master_bit_engine dut (.*);

    i2cm_checker line_check (.*);

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) cycle_no <= cycle_no + 1;

    initial begin
        int n;
        n = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            n++;
            if ((n >= 150 && n < 214) || (n >= 900 && n < 980)) begin
                m_ready <= 1'b0;
            end else if (n >= QUIET_FROM && n < QUIET_TO) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 13);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAIL i2c_master_bit_engine");
        $finish;
    end

    task automatic offer_tick(i2cm_pkg::cmd_t c, logic [7:0] tx, logic ak, logic sd);
        while (!(cycle_no >= QUIET_FROM && cycle_no < QUIET_TO) &&
               $urandom_range(0, 99) < 13) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= c;
        s_tx_byte        <= tx;
        s_ack_after_read <= ak;
        s_sda_in         <= sd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Issues one command on an idle engine and ticks it to completion. A
    // non-negative high_run holds SDA high for that many ticks, then low.
    task automatic run_command(i2cm_pkg::cmd_t c, logic [7:0] tx, logic ak, int high_run,
                               int noise_pct);
        int n;
        i2cm_pkg::cmd_t cur;
        logic sd;
        n = 0;
        cur = c;
        do begin
            sd = (high_run < 0) ? 1'($urandom_range(0, 1)) : (n < high_run);
            offer_tick(cur, tx, ak, sd);
            n++;
            tx = 8'($urandom_range(0, 255));
            ak = 1'($urandom_range(0, 1));
            cur = ($urandom_range(0, 99) < noise_pct)
                  ? i2cm_pkg::cmd_t'($urandom_range(1, 7)) : i2cm_pkg::CMD_NONE;
        end while (engine_busy);
    endtask

    function automatic int ack_delay();
        return ($urandom_range(0, 9) == 0) ? 1000 : $urandom_range(0, 5);
    endfunction

    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [i2cm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic random_transaction();
        i2cm_pkg::cmd_t c;
        if ($urandom_range(0, 4) == 0) begin
            c = i2cm_pkg::cmd_t'($urandom_range(0, 7));
            run_command(c, 8'($urandom), 1'($urandom),
                        (c == i2cm_pkg::CMD_WAIT_ACK) ? ack_delay() : -1, 10);
        end else begin
            run_command(i2cm_pkg::CMD_START, 8'($urandom), 1'($urandom), -1, 10);
            run_command(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom), -1, 10);
            run_command(i2cm_pkg::CMD_WAIT_ACK, 8'($urandom), 1'($urandom),
                        ack_delay(), 10);
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 3))
                    0: begin
                        run_command(i2cm_pkg::CMD_WRITE, 8'($urandom), 1'($urandom),
                                    -1, 10);
                        run_command(i2cm_pkg::CMD_WAIT_ACK, 8'($urandom), 1'($urandom),
                                    ack_delay(), 10);
                    end
                    1: run_command(i2cm_pkg::CMD_READ, 8'($urandom), 1'($urandom), -1, 10);
                    2: run_command(i2cm_pkg::CMD_ACK, 8'($urandom), 1'($urandom), -1, 10);
                    default: begin
                        run_command(i2cm_pkg::CMD_NACK, 8'($urandom), 1'($urandom),
                                    -1, 10);
                    end
                endcase
            end
            run_command(i2cm_pkg::CMD_STOP, 8'($urandom), 1'($urandom), -1, 10);
        end
        repeat ($urandom_range(0, 2)) begin
            run_command(i2cm_pkg::CMD_NONE, 8'($urandom), 1'($urandom), -1, 0);
        end
    endtask

    initial begin
        int phase_end;
        logic [7:0] hold_v, half_v, tmo_v;
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = 8'd0;
        s_valid          = 1'b0;
        s_command        = i2cm_pkg::CMD_NONE;
        s_tx_byte        = 8'd0;
        s_ack_after_read = 1'b0;
        s_sda_in         = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_command(i2cm_pkg::CMD_NONE, 8'h00, 1'b0, -1, 0);
        run_command(i2cm_pkg::CMD_START, 8'h00, 1'b0, -1, 0);
        run_command(i2cm_pkg::CMD_WRITE, 8'h00, 1'b0, -1, 0);
        run_command(i2cm_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 0, 0);
        // Every tick during this write carries a command that must be ignored.
        run_command(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1, -1, 100);
        run_command(i2cm_pkg::CMD_WAIT_ACK, 8'hFF, 1'b1, 5, 0);
        run_command(i2cm_pkg::CMD_READ, 8'h00, 1'b1, 1000, 0);
        run_command(i2cm_pkg::CMD_READ, 8'hFF, 1'b0, 0, 0);
        run_command(i2cm_pkg::CMD_READ, 8'h5A, 1'b1, -1, 0);
        run_command(i2cm_pkg::CMD_ACK, 8'h00, 1'b0, -1, 0);
        run_command(i2cm_pkg::CMD_NACK, 8'hFF, 1'b1, -1, 0);
        run_command(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, -1, 0);
        run_command(i2cm_pkg::CMD_START, 8'hA5, 1'b0, -1, 0);
        run_command(i2cm_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 1000, 0);
        run_command(i2cm_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 2, 0);

        for (int k = 0; k < 5; k++) begin
            if (k < 4) begin
                {hold_v, half_v, tmo_v} = CFG_PLAN[k];
            end else begin
                hold_v = 8'($urandom_range(1, 6));
                half_v = 8'($urandom_range(1, 6));
                tmo_v  = 8'($urandom_range(1, 6));
            end
            settle();
            write_reg(i2cm_pkg::CFG_IDX_START_STOP_HOLD, hold_v);
            write_reg(i2cm_pkg::CFG_IDX_BIT_HALF, half_v);
            write_reg(i2cm_pkg::CFG_IDX_ACK_TIMEOUT, tmo_v);
            cfg_valid <= 1'b0;
            phase_end = items_sent + 40;
            while (items_sent < phase_end) random_transaction();
        end

        settle();
        if (fail_count == 0) begin
            $display("PASS i2c_master_bit_engine");
        end else begin
            $display("FAIL i2c_master_bit_engine");
        end
        $finish;
    end

endmodule
